### rtl/syllable_estimator_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the syllable estimator checker
// ----------------------------------------------------------------------------
`ifndef SYLLABLE_ESTIMATOR_UNIT_DEFINES_SVH
`define SYLLABLE_ESTIMATOR_UNIT_DEFINES_SVH

// Clocked property, ignored while reset is asserted
`define SEU_ASSERT_CLK(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("syllable estimator check failed");

// Clocked property, checked in and out of reset
`define SEU_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("syllable estimator check failed");

`endif

### rtl/sylest_pkg.sv
// ----------------------------------------------------------------------------
// sylest_pkg
// Transaction types and character constants for the syllable estimator.
// ----------------------------------------------------------------------------
package sylest_pkg;

  // Input transaction: one character of a word
  typedef struct packed {
    logic [7:0] char_code;
    logic       word_end;
    logic       list_start;
  } in_t;

  // Result transaction: one finished word
  typedef struct packed {
    logic [7:0]  syllables;
    logic        is_complex;
    logic [15:0] complex_total;
  } out_t;

  // Character class of one folded byte
  typedef struct packed {
    logic is_vowel;
    logic is_e;
    logic is_l;
  } char_class_t;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;
  localparam logic [7:0] CHAR_A       = 8'h61;
  localparam logic [7:0] CHAR_E       = 8'h65;
  localparam logic [7:0] CHAR_I       = 8'h69;
  localparam logic [7:0] CHAR_L       = 8'h6C;
  localparam logic [7:0] CHAR_O       = 8'h6F;
  localparam logic [7:0] CHAR_U       = 8'h75;
  localparam logic [7:0] CHAR_Y       = 8'h79;

  localparam logic [7:0]  GROUP_MAX       = 8'hFF;
  localparam logic [7:0]  COMPLEX_MIN_SYL = 8'd3;
  localparam logic [15:0] TOTAL_OUT_MAX   = 16'hFFFF;

endpackage

### rtl/sylest_char_class.sv
// ----------------------------------------------------------------------------
// sylest_char_class
// Folds ASCII upper case and classifies the byte as vowel, 'e' or 'l'.
// ----------------------------------------------------------------------------
module sylest_char_class import sylest_pkg::*; (
  input  logic [7:0]  char_code,
  output char_class_t char_class
);

  logic [7:0] folded;

  // Fold A..Z onto a..z, leave every other byte as it is
  always_comb begin
    if (char_code >= CHAR_UPPER_A && char_code <= CHAR_UPPER_Z) begin
      folded = char_code + CASE_OFFSET;
    end else begin
      folded = char_code;
    end
  end

  // Classify the folded byte
  always_comb begin
    char_class.is_e     = (folded == CHAR_E);
    char_class.is_l     = (folded == CHAR_L);
    char_class.is_vowel = (folded == CHAR_A) || (folded == CHAR_E) ||
                          (folded == CHAR_I) || (folded == CHAR_O) ||
                          (folded == CHAR_U) || (folded == CHAR_Y);
  end

endmodule

### rtl/syllable_estimator_unit.sv
// ----------------------------------------------------------------------------
// syllable_estimator_unit
// Vowel-group syllable estimate per word with a running complex-word count.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one character per transaction (char_code, word_end, list_start).
//           list_start clears the complex-word count before the character is
//           used; word_end marks the last character of a word.
//   out_* : one result per word, issued for the transaction carrying word_end:
//           syllables, is_complex and the running complex_total.
//   Throughput: one character per cycle while in_ready is high; the
//   per-character logic (case fold, vowel compare, group increment, final-'e'
//   rule) sits between the word state registers and the result register.
//   Latency: a result is valid in the cycle after its last character is
//   accepted.
//   Reset: synchronous on rst_n; clears the word state, the complex count and
//   the result valid flag.
//   Stall: while a result waits on out_ready, in_ready is low and no input
//   transaction is accepted; in_ready follows out_ready, so a full register
//   that is emptied in the same cycle still takes the next character.
// ----------------------------------------------------------------------------
module syllable_estimator_unit import sylest_pkg::*; #(
  parameter int TOTAL_WIDTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  char_class_t            cls;
  logic                   in_fire;
  logic                   vg_r;
  logic                   vg_nxt;
  logic [7:0]             grp_r;
  logic [7:0]             grp_nxt;
  logic [7:0]             grp_inc;
  logic                   prev_l_r;
  logic                   prev_l_nxt;
  logic [TOTAL_WIDTH-1:0] cnt_r;
  logic [TOTAL_WIDTH-1:0] cnt_nxt;
  logic [TOTAL_WIDTH-1:0] cnt_base;
  logic [TOTAL_WIDTH-1:0] cnt_word;
  logic [31:0]            cnt_ext;
  logic [7:0]             syl;
  logic                   cx;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  out_t                   out_data_r;
  out_t                   out_data_nxt;

  sylest_char_class u_class (
    .char_code  (in_data.char_code),
    .char_class (cls)
  );

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Advance the vowel group count, saturating
  always_comb begin
    if (cls.is_vowel && !vg_r && grp_r != GROUP_MAX) begin
      grp_inc = grp_r + 8'd1;
    end else begin
      grp_inc = grp_r;
    end
  end

  // Drop a silent final 'e', force at least one syllable
  always_comb begin
    if (cls.is_e && !prev_l_r && grp_inc > 8'd1) begin
      syl = grp_inc - 8'd1;
    end else if (grp_inc == 8'd0) begin
      syl = 8'd1;
    end else begin
      syl = grp_inc;
    end
    cx = (syl >= COMPLEX_MIN_SYL);
  end

  // Complex count: clear on list start, raise on a complex word, saturating
  always_comb begin
    cnt_base = in_data.list_start ? '0 : cnt_r;
    if (cx && !(&cnt_base)) begin
      cnt_word = cnt_base + {{(TOTAL_WIDTH-1){1'b0}}, 1'b1};
    end else begin
      cnt_word = cnt_base;
    end
    cnt_ext = 32'(cnt_word);
  end

  // Next state and result
  always_comb begin
    vg_nxt        = vg_r;
    grp_nxt       = grp_r;
    prev_l_nxt    = prev_l_r;
    cnt_nxt       = cnt_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (in_fire) begin
      if (in_data.word_end) begin
        vg_nxt                     = 1'b0;
        grp_nxt                    = '0;
        prev_l_nxt                 = 1'b0;
        cnt_nxt                    = cnt_word;
        out_valid_nxt              = 1'b1;
        out_data_nxt.syllables     = syl;
        out_data_nxt.is_complex    = cx;
        out_data_nxt.complex_total = (cnt_ext > 32'(TOTAL_OUT_MAX)) ?
                                     TOTAL_OUT_MAX : cnt_ext[15:0];
      end else begin
        vg_nxt     = cls.is_vowel;
        grp_nxt    = grp_inc;
        prev_l_nxt = cls.is_l;
        cnt_nxt    = cnt_base;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vg_r        <= 1'b0;
      grp_r       <= '0;
      prev_l_r    <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vg_r        <= vg_nxt;
      grp_r       <= grp_nxt;
      prev_l_r    <= prev_l_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/sylest_checker.sv
// ----------------------------------------------------------------------------
// sylest_checker
// Port-level checks for the syllable estimator, bound to the top level.
// ----------------------------------------------------------------------------
`include "syllable_estimator_unit_defines.svh"

module sylest_checker import sylest_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input in_t  in_data,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  logic out_stall;
  logic in_word_end;
  logic syl_complex;

  assign out_stall   = out_valid && !out_ready;
  assign in_word_end = in_valid && in_ready && in_data.word_end;
  assign syl_complex = (out_data.syllables >= COMPLEX_MIN_SYL);

  // Hold a stalled result
  `SEU_ASSERT_CLK(a_out_hold, clk, rst_n, out_stall |=> out_valid && $stable(out_data))

  // A new result follows only a word-ending transaction
  `SEU_ASSERT_CLK(a_out_after_word_end, clk, rst_n, $rose(out_valid) |-> $past(in_word_end))

  // A word always has at least one syllable
  `SEU_ASSERT_CLK(a_syl_nonzero, clk, rst_n, out_valid |-> out_data.syllables != 8'd0)

  // Complex flag agrees with the syllable count
  `SEU_ASSERT_CLK(a_complex_flag, clk, rst_n, out_valid |-> out_data.is_complex == syl_complex)

endmodule

bind syllable_estimator_unit sylest_checker u_sylest_checker (.*);
